// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file efr_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define EFR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define EFR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/efr_pkg.sv =====
package efr_pkg;

  localparam int FRAME_CAPACITY = 1024;
  localparam int COMMAND_LENGTH = 7;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 11;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int COUNT_W   = $clog2(FRAME_CAPACITY + 1);
  localparam int CMD_IDX_W = $clog2(COMMAND_LENGTH);

  localparam logic [BYTE_W-1:0] ESCAPE_CHAR_RST = 8'h7d;
  localparam logic [BYTE_W-1:0] ESCAPE_MASK_RST = 8'h20;
  localparam logic [BYTE_W-1:0] HEAD_CHAR_RST   = 8'h23;
  localparam logic [BYTE_W-1:0] TAIL_CHAR_RST   = 8'h40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ESCAPE_CHAR = 2'd0,
    CFG_ESCAPE_MASK = 2'd1,
    CFG_HEAD_CHAR   = 2'd2,
    CFG_TAIL_CHAR   = 2'd3
  } cfg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE = 2'd0,
    KIND_JUMP = 2'd1,
    KIND_INFO = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              data_valid;
    logic              frame_begin;
    logic              frame_end;
    logic [LEN_W-1:0]  frame_length;
    cmd_kind_t         command_kind;
    logic              overflow;
  } efr_result_t;

  // Jump command: '#', 0x00, 0x01, 'J', 0xff, 0xff, '@'
  function automatic logic [BYTE_W-1:0] jump_byte(input logic [CMD_IDX_W-1:0] idx);
    logic [BYTE_W-1:0] val;
    case (idx)
      3'd0:    val = 8'h23;
      3'd1:    val = 8'h00;
      3'd2:    val = 8'h01;
      3'd3:    val = 8'h4a;
      3'd4:    val = 8'hff;
      3'd5:    val = 8'hff;
      3'd6:    val = 8'h40;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // Firmware-info command: same as jump but 'G' in place of 'J'
  function automatic logic [BYTE_W-1:0] info_byte(input logic [CMD_IDX_W-1:0] idx);
    logic [BYTE_W-1:0] val;
    case (idx)
      3'd0:    val = 8'h23;
      3'd1:    val = 8'h00;
      3'd2:    val = 8'h01;
      3'd3:    val = 8'h47;
      3'd4:    val = 8'hff;
      3'd5:    val = 8'hff;
      3'd6:    val = 8'h40;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// ===== hw/rtl/efr_in_if.sv =====
interface efr_in_if import efr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/efr_out_if.sv =====
interface efr_out_if import efr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              data_valid;
  logic              frame_begin;
  logic              frame_end;
  logic [LEN_W-1:0]  frame_length;
  logic [KIND_W-1:0] command_kind;
  logic              overflow;

  modport source (output valid, output data_byte, output data_valid, output frame_begin,
                  output frame_end, output frame_length, output command_kind,
                  output overflow, input ready);
  modport sink   (input valid, input data_byte, input data_valid, input frame_begin,
                  input frame_end, input frame_length, input command_kind,
                  input overflow, output ready);
endinterface

// ===== hw/rtl/escaped_frame_receiver.sv =====
// Byte-stuffed frame receiver.
// in_rx carries one raw link byte per item; out_res returns exactly one result
// item per input item, in order: the unescaped byte, whether it joined a frame,
// frame begin/end marks, running frame length, overflow and, on the tail, the
// command match (jump, firmware info or none).
// cfg_we/cfg_idx/cfg_data write the escape char, escape mask, head char and tail
// char; write them only while no item is in flight.
// The result is registered and shows on out_res in the cycle after acceptance.
// Throughput: one item per cycle unless out_res stalls; the per-byte decision is
// compares, a pattern lookup and a counter increment before the result register.
// in_rx.ready stays high while the result register is empty or being drained, so
// an item is taken in the same cycle the previous result leaves.
// When the consumer stalls, the result holds and in_rx.ready drops until it is
// taken; no item is lost or repeated.
// Reset (synchronous, rst_n low) clears the frame state and output valid and
// restores the default delimiter settings.
module escaped_frame_receiver import efr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [BYTE_W-1:0]    cfg_data,
  efr_in_if.sink               in_rx,
  efr_out_if.source            out_res
);

  logic [BYTE_W-1:0] esc_char_r, esc_mask_r, head_char_r, tail_char_r;

  logic               pend_r, pend_nxt;
  logic               in_frame_r, in_frame_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic               jm_r, jm_nxt;
  logic               im_r, im_nxt;
  logic               ovf_r, ovf_nxt;

  logic        out_valid_r, out_valid_nxt;
  efr_result_t res_r, res_nxt;

  logic               in_fire;
  logic               is_marker, escaped, is_head, is_tail;
  logic [BYTE_W-1:0]  b;
  logic [COUNT_W-1:0] base_cnt, cnt_take;
  logic               base_jm, base_im, base_ovf;
  logic               idx_small, sat;
  logic               jm_take, im_take, ovf_take;
  logic [CMD_IDX_W-1:0] idx;

  assign in_rx.ready = !out_valid_r || out_res.ready;
  assign in_fire     = in_rx.valid && in_rx.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_char_r  <= ESCAPE_CHAR_RST;
      esc_mask_r  <= ESCAPE_MASK_RST;
      head_char_r <= HEAD_CHAR_RST;
      tail_char_r <= TAIL_CHAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_ESCAPE_CHAR: esc_char_r  <= cfg_data;
        CFG_ESCAPE_MASK: esc_mask_r  <= cfg_data;
        CFG_HEAD_CHAR:   head_char_r <= cfg_data;
        CFG_TAIL_CHAR:   tail_char_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    is_marker = (in_rx.rx_byte == esc_char_r) && !pend_r;
    escaped   = pend_r;
    b         = pend_r ? (in_rx.rx_byte ^ esc_mask_r) : in_rx.rx_byte;
    is_head   = !escaped && (b == head_char_r);
    is_tail   = !escaped && (b == tail_char_r);

    // a head restarts the frame before the byte is counted
    base_cnt  = is_head ? '0 : cnt_r;
    base_jm   = is_head ? 1'b1 : jm_r;
    base_im   = is_head ? 1'b1 : im_r;
    base_ovf  = is_head ? 1'b0 : ovf_r;

    idx_small = base_cnt < COUNT_W'(COMMAND_LENGTH);
    idx       = base_cnt[CMD_IDX_W-1:0];
    jm_take   = base_jm && (!idx_small || (b == jump_byte(idx)));
    im_take   = base_im && (!idx_small || (b == info_byte(idx)));
    sat       = base_cnt >= COUNT_W'(FRAME_CAPACITY);
    cnt_take  = sat ? base_cnt : base_cnt + COUNT_W'(1);
    ovf_take  = base_ovf || sat;

    pend_nxt     = pend_r;
    in_frame_nxt = in_frame_r;
    cnt_nxt      = cnt_r;
    jm_nxt       = jm_r;
    im_nxt       = im_r;
    ovf_nxt      = ovf_r;

    res_nxt              = '0;
    res_nxt.command_kind = KIND_NONE;

    if (is_marker) begin
      pend_nxt          = 1'b1;
      res_nxt.data_byte = '0;
    end else begin
      pend_nxt          = 1'b0;
      res_nxt.data_byte = b;
      if (is_head || in_frame_r) begin
        in_frame_nxt       = 1'b1;
        cnt_nxt            = cnt_take;
        jm_nxt             = jm_take;
        im_nxt             = im_take;
        ovf_nxt            = ovf_take;
        res_nxt.data_valid = 1'b1;
        if (is_head) begin
          res_nxt.frame_begin = 1'b1;
        end else if (is_tail) begin
          in_frame_nxt      = 1'b0;
          res_nxt.frame_end = 1'b1;
          if (cnt_take >= COUNT_W'(COMMAND_LENGTH)) begin
            if (jm_take) begin
              res_nxt.command_kind = KIND_JUMP;
            end else if (im_take) begin
              res_nxt.command_kind = KIND_INFO;
            end
          end
        end
      end
    end

    if (in_frame_nxt || res_nxt.frame_end) begin
      res_nxt.frame_length = LEN_W'(cnt_nxt);
      res_nxt.overflow     = ovf_nxt;
    end

    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      in_frame_r  <= 1'b0;
      cnt_r       <= '0;
      jm_r        <= 1'b0;
      im_r        <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        pend_r     <= pend_nxt;
        in_frame_r <= in_frame_nxt;
        cnt_r      <= cnt_nxt;
        jm_r       <= jm_nxt;
        im_r       <= im_nxt;
        ovf_r      <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.data_byte    = res_r.data_byte;
  assign out_res.data_valid   = res_r.data_valid;
  assign out_res.frame_begin  = res_r.frame_begin;
  assign out_res.frame_end    = res_r.frame_end;
  assign out_res.frame_length = res_r.frame_length;
  assign out_res.command_kind = res_r.command_kind;
  assign out_res.overflow     = res_r.overflow;

endmodule

// ===== hw/rtl/efr_checker.sv =====
`include "assert_macros.svh"

module efr_checker import efr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              data_valid,
  input logic              frame_begin,
  input logic              frame_end,
  input logic [LEN_W-1:0]  frame_length,
  input logic [KIND_W-1:0] command_kind,
  input logic              overflow
);

  `EFR_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `EFR_ASSERT_NEVER(a_end_without_data, clk, rst_n, out_valid && frame_end && (!data_valid || frame_begin), "tail item not marked as frame data")
  `EFR_ASSERT_NEVER(a_kind_off_tail, clk, rst_n, out_valid && !frame_end && (command_kind != KIND_NONE), "command kind outside frame end")
  `EFR_ASSERT_NEVER(a_begin_len, clk, rst_n, out_valid && frame_begin && ((frame_length != LEN_W'(1)) || overflow), "new frame does not start at length one")
  `EFR_ASSERT_NEVER(a_begin_no_data, clk, rst_n, out_valid && frame_begin && !data_valid, "frame begin without data")

endmodule

bind escaped_frame_receiver efr_checker u_efr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .data_valid   (out_res.data_valid),
  .frame_begin  (out_res.frame_begin),
  .frame_end    (out_res.frame_end),
  .frame_length (out_res.frame_length),
  .command_kind (out_res.command_kind),
  .overflow     (out_res.overflow)
);
